// ===== rtl/atrf_pkg.sv =====
// Shared types and constants for the API transmit-request framer.
// Item structs for both channels, the internal command format and byte codes.
// No dependencies; every other file imports this package.
package atrf_pkg;

  // Channel items
  typedef struct packed {
    logic        req_type;
    logic [63:0] dest_addr;
    logic [7:0]  payload_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_IDENT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSMIT_OPTIONS = 2'd2;

  localparam logic [7:0] FRAME_IDENT_RST      = 8'h01;
  localparam logic [7:0] BROADCAST_RADIUS_RST = 8'h00;
  localparam logic [7:0] TRANSMIT_OPTIONS_RST = 8'h00;

  // Frame constants
  localparam logic [7:0]  DELIM_BYTE      = 8'h7E;
  localparam logic [7:0]  TYPE_TX_REQ     = 8'h10;
  localparam logic [15:0] RESERVED_WORD   = 16'hFFFE;
  localparam logic [8:0]  HEADER_OVERHEAD = 9'd14;
  localparam logic [7:0]  CKSUM_BASE      = 8'hFF;
  localparam logic [7:0]  MAX_PAYLOAD     = 8'd255;

  // Command handed from the front to the back
  typedef struct packed {
    logic        is_start;
    logic        last;         // start: empty payload; data: final payload byte
    logic [63:0] dest_addr;
    logic [7:0]  payload_len;
    logic [7:0]  data_byte;
    logic [7:0]  frame_ident;
    logic [7:0]  radius;
    logic [7:0]  options;
  } cmd_t;

  // Queue sizes
  localparam int unsigned CMDQ_AW    = 1;
  localparam int unsigned CMDQ_DEPTH = 1 << CMDQ_AW;
  localparam int unsigned OUTQ_AW    = 1;
  localparam int unsigned OUTQ_DEPTH = 1 << OUTQ_AW;

  // Sequencer steps
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_DELIM      = 5'd0;
  localparam logic [STEP_W-1:0] STEP_LEN_HI     = 5'd1;
  localparam logic [STEP_W-1:0] STEP_LEN_LO     = 5'd2;
  localparam logic [STEP_W-1:0] STEP_TYPE       = 5'd3;
  localparam logic [STEP_W-1:0] STEP_IDENT      = 5'd4;
  localparam logic [STEP_W-1:0] STEP_ADDR_FIRST = 5'd5;
  localparam logic [STEP_W-1:0] STEP_ADDR_LAST  = 5'd12;
  localparam logic [STEP_W-1:0] STEP_RSV_HI     = 5'd13;
  localparam logic [STEP_W-1:0] STEP_RSV_LO     = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RADIUS     = 5'd15;
  localparam logic [STEP_W-1:0] STEP_OPTIONS    = 5'd16;
  localparam logic [STEP_W-1:0] STEP_HDR_CKSUM  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_DATA       = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DATA_CKSUM = 5'd1;

endpackage

// ===== rtl/atrf_front.sv =====
// Front end: input acceptance, configuration registers, frame tracking.
// Classifies each item into a command for the back end or drops it.
// Depends on atrf_pkg.
module atrf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  atrf_pkg::in_item_t              in_item,
  output logic                            in_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [atrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  output logic                            cmd_push,
  output atrf_pkg::cmd_t                  cmd,
  input  logic                            cmdq_full
);
  import atrf_pkg::*;

  logic [7:0] frame_ident_r, radius_r, options_r;
  logic       frame_open_r, frame_open_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       accept;
  logic [7:0] len_sat;

  assign cfg_ready = 1'b1;
  assign in_full   = cmdq_full;
  assign accept    = in_push && !cmdq_full;
  assign len_sat   = (in_item.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in_item.payload_len;

  always_comb begin
    cmd.is_start    = (in_item.req_type == REQ_START);
    cmd.dest_addr   = in_item.dest_addr;
    cmd.payload_len = len_sat;
    cmd.data_byte   = in_item.data_byte;
    cmd.frame_ident = frame_ident_r;
    cmd.radius      = radius_r;
    cmd.options     = options_r;
    cmd.last        = cmd.is_start ? (len_sat == 8'd0) : (bytes_left_r == 8'd1);
    cmd_push        = accept && (cmd.is_start || frame_open_r);

    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    if (accept) begin
      if (cmd.is_start) begin
        // abandon whatever frame was open
        frame_open_nxt = (len_sat != 8'd0);
        bytes_left_nxt = len_sat;
      end else if (frame_open_r) begin
        bytes_left_nxt = bytes_left_r - 8'd1;
        frame_open_nxt = (bytes_left_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ident_r <= FRAME_IDENT_RST;
      radius_r      <= BROADCAST_RADIUS_RST;
      options_r     <= TRANSMIT_OPTIONS_RST;
      frame_open_r  <= 1'b0;
      bytes_left_r  <= 8'd0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_IDENT:      frame_ident_r <= cfg_data;
          CFG_BROADCAST_RADIUS: radius_r      <= cfg_data;
          CFG_TRANSMIT_OPTIONS: options_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/atrf_cmd_queue.sv =====
// Short command queue between the front and back ends.
// Holds CMDQ_DEPTH commands; the head is shown while valid is high.
// Depends on atrf_pkg.
module atrf_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atrf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output atrf_pkg::cmd_t head_cmd
);
  import atrf_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid    = (count_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/atrf_back.sv =====
// Back end: byte sequencer, checksum accumulator and result queue.
// Expands each command into frame bytes, one per cycle while the result queue has room.
// Depends on atrf_pkg.
module atrf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  atrf_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output atrf_pkg::out_item_t out_item
);
  import atrf_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              emit, done;
  logic [7:0]        byte_val;
  logic              is_cksum, summed;
  logic [8:0]        total;
  logic [2:0]        addr_idx;
  logic [STEP_W-1:0] addr_off;

  out_item_t          q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_AW:0]   count_r, count_nxt;
  logic               q_full, do_pop;

  assign q_full    = (count_r == (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign out_empty = (count_r == '0);
  assign out_item  = q_r[rd_ptr_r];
  assign do_pop    = out_pop && !out_empty;
  assign emit      = cmd_valid && !q_full;

  assign total    = {1'b0, cmd.payload_len} + HEADER_OVERHEAD;
  assign addr_off = step_r - STEP_ADDR_FIRST;
  assign addr_idx = addr_off[2:0];

  always_comb begin
    byte_val = 8'h00;
    is_cksum = 1'b0;
    if (cmd.is_start) begin
      case (step_r)
        STEP_DELIM:     byte_val = DELIM_BYTE;
        STEP_LEN_HI:    byte_val = {7'd0, total[8]};
        STEP_LEN_LO:    byte_val = total[7:0];
        STEP_TYPE:      byte_val = TYPE_TX_REQ;
        STEP_IDENT:     byte_val = cmd.frame_ident;
        STEP_RSV_HI:    byte_val = RESERVED_WORD[15:8];
        STEP_RSV_LO:    byte_val = RESERVED_WORD[7:0];
        STEP_RADIUS:    byte_val = cmd.radius;
        STEP_OPTIONS:   byte_val = cmd.options;
        STEP_HDR_CKSUM: begin
          byte_val = CKSUM_BASE - sum_r;
          is_cksum = 1'b1;
        end
        default: begin
          // address bytes, most significant first
          case (addr_idx)
            3'd0:    byte_val = cmd.dest_addr[63:56];
            3'd1:    byte_val = cmd.dest_addr[55:48];
            3'd2:    byte_val = cmd.dest_addr[47:40];
            3'd3:    byte_val = cmd.dest_addr[39:32];
            3'd4:    byte_val = cmd.dest_addr[31:24];
            3'd5:    byte_val = cmd.dest_addr[23:16];
            3'd6:    byte_val = cmd.dest_addr[15:8];
            default: byte_val = cmd.dest_addr[7:0];
          endcase
        end
      endcase
      summed = (step_r >= STEP_TYPE) && (step_r <= STEP_OPTIONS);
      done   = (step_r == STEP_HDR_CKSUM) || ((step_r == STEP_OPTIONS) && !cmd.last);
    end else begin
      if (step_r == STEP_DATA_CKSUM) begin
        byte_val = CKSUM_BASE - sum_r;
        is_cksum = 1'b1;
      end else begin
        byte_val = cmd.data_byte;
      end
      summed = (step_r == STEP_DATA);
      done   = (step_r == STEP_DATA_CKSUM) || ((step_r == STEP_DATA) && !cmd.last);
    end
  end

  assign cmd_pop = emit && done;

  always_comb begin
    step_nxt = step_r;
    sum_nxt  = sum_r;
    if (emit) begin
      step_nxt = done ? '0 : step_r + 1'b1;
      // restart the sum on the frame type byte
      if (cmd.is_start && step_r == STEP_TYPE) sum_nxt = byte_val;
      else if (summed) sum_nxt = sum_r + byte_val;
    end
    count_nxt = count_r;
    if (emit && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !emit) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      sum_r    <= 8'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      step_r  <= step_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      if (emit)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      q_r[wr_ptr_r].frame_byte <= byte_val;
      q_r[wr_ptr_r].frame_end  <= is_cksum;
    end
  end

endmodule

// ===== rtl/api_tx_request_framer.sv =====
// Top level of the API transmit-request framer.
// Ties front end, command queue and back end; depends on atrf_pkg and all atrf_ modules.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   in_      | in        | in_push / in_full       | in_item (in_item_t)
//   out_     | out       | out_pop / out_empty     | out_item (out_item_t)
//   cfg_     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// The back end emits one frame byte per cycle while the result queue has room: a start
// item gives 17 bytes (18 with an empty payload), a data item 1 (2 on the final byte).
// Data items pass at one per cycle while the result queue has room; a header burst
// fills the two-entry command queue and raises in_full until the sequencer drains it.
// Synchronous active-low reset clears queues, frame tracking and registers.
// A stalled result side fills the two-entry result queue and then stalls the back end.
module api_tx_request_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  atrf_pkg::in_item_t              in_item,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output atrf_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [atrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import atrf_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic cmd_push, cmdq_full, cmd_valid, cmd_pop;

  atrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .cmdq_full (cmdq_full)
  );

  atrf_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .full     (cmdq_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head_cmd (head_cmd)
  );

  atrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== tb/tb_api_tx_request_framer.sv =====
// Self-checking testbench for api_tx_request_framer: directed and random request items,
// register phases and randomly idling queue handshakes on both sides.
// Depends on atrf_pkg and the framer RTL; the expected frame bytes are predicted locally.
module tb_api_tx_request_framer;
  import atrf_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 80;
  localparam int NUM_PHASES    = 5;
  localparam int REPORT_LIMIT  = 10;

  // Frame byte predictor and the queue of bytes it expects from the block
  class frame_scoreboard;
    logic [7:0] ident;
    logic [7:0] radius;
    logic [7:0] options;
    logic [7:0] bytes_left;
    logic [7:0] running_sum;
    bit         frame_open;
    out_item_t  pending_bytes[$];
    int errors;
    int checked;
    int frames_closed;
    int starts;
    int payload_items;
    int ignored_items;

    function new();
      ident         = FRAME_IDENT_RST;
      radius        = BROADCAST_RADIUS_RST;
      options       = TRANSMIT_OPTIONS_RST;
      bytes_left    = '0;
      running_sum   = '0;
      frame_open    = 1'b0;
      errors        = 0;
      checked       = 0;
      frames_closed = 0;
      starts        = 0;
      payload_items = 0;
      ignored_items = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_FRAME_IDENT:      ident = val;
        CFG_BROADCAST_RADIUS: radius = val;
        CFG_TRANSMIT_OPTIONS: options = val;
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b, logic last);
      out_item_t e;
      e.frame_byte = b;
      e.frame_end  = last;
      pending_bytes.push_back(e);
    endfunction

    function void push_summed(logic [7:0] b);
      running_sum = running_sum + b;
      push_byte(b, 1'b0);
    endfunction

    function void push_checksum();
      push_byte(CKSUM_BASE - running_sum, 1'b1);
      frame_open  = 1'b0;
      bytes_left  = '0;
      running_sum = '0;
    endfunction

    function void note_request(in_item_t it);
      logic [15:0] total;
      if (it.req_type == REQ_START) begin
        starts++;
        total = {8'd0, it.payload_len} + 16'(HEADER_OVERHEAD);
        running_sum = '0;
        push_byte(DELIM_BYTE, 1'b0);
        push_byte(total[15:8], 1'b0);
        push_byte(total[7:0], 1'b0);
        push_summed(TYPE_TX_REQ);
        push_summed(ident);
        for (int i = 7; i >= 0; i--) push_summed(it.dest_addr[i*8 +: 8]);
        push_summed(RESERVED_WORD[15:8]);
        push_summed(RESERVED_WORD[7:0]);
        push_summed(radius);
        push_summed(options);
        // an empty payload closes the frame right after the header
        if (it.payload_len == 8'd0) begin
          push_checksum();
        end else begin
          frame_open = 1'b1;
          bytes_left = it.payload_len;
        end
      end else if (!frame_open) begin
        ignored_items++;
      end else begin
        payload_items++;
        push_summed(it.data_byte);
        if (bytes_left > 8'd0) bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) push_checksum();
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void check_byte(out_item_t got);
      out_item_t exp;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("unexpected frame byte %02h end %0b", got.frame_byte, got.frame_end));
      end else begin
        exp = pending_bytes.pop_front();
        checked++;
        if (got.frame_end) frames_closed++;
        if (got.frame_byte !== exp.frame_byte)
          flag($sformatf("byte %0d: frame_byte expected %02h, got %02h",
                         checked, exp.frame_byte, got.frame_byte));
        if (got.frame_end !== exp.frame_end)
          flag($sformatf("byte %0d: frame_end expected %0b, got %0b",
                         checked, exp.frame_end, got.frame_end));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  in_item_t             in_item = '0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  frame_scoreboard sb;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_request = 1'b0;
  int holds_done = 0;
  int idle_cycles = 0;
  int settings_done = 0;

  api_tx_request_framer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic in_item_t start_item(logic [63:0] addr, logic [7:0] len);
    in_item_t it;
    it.req_type    = REQ_START;
    it.dest_addr   = addr;
    it.payload_len = len;
    it.data_byte   = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t data_item(logic [7:0] b);
    in_item_t it;
    it.req_type    = REQ_DATA;
    it.dest_addr   = {$urandom(), $urandom()};
    it.payload_len = 8'($urandom);
    it.data_byte   = b;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    sb.note_request(it);
  endtask

  // Drain all expected bytes, then give the block time to finish dropped items
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [7:0] fi, logic [7:0] br, logic [7:0] to, bit poke_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [7:0]           val [4];
    int n;
    idx[0] = CFG_FRAME_IDENT;      val[0] = fi;
    idx[1] = CFG_BROADCAST_RADIUS; val[1] = br;
    idx[2] = CFG_TRANSMIT_OPTIONS; val[2] = to;
    idx[3] = '1;                   val[3] = 8'($urandom);
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Result side: pop with random gaps, one long hold on request
  initial begin : result_side
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(rx_quiet);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
        holds_done++;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_byte(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d bytes outstanding",
                 IDLE_LIMIT, sb.pending_bytes.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int budget;
    int r;
    int n;
    int len;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset register values
    send_item(data_item(8'hFF));                              // no frame open: drop
    send_item(start_item(64'h0, 8'd0));                       // empty payload
    send_item(start_item('1, 8'd1));
    send_item(data_item(8'h00));
    send_item(data_item(8'hA5));                              // frame closed: drop
    send_item(start_item(64'h0123_4567_89AB_CDEF, 8'd255));
    send_item(data_item(8'hFF));
    send_item(data_item(8'h80));
    send_item(start_item(64'hFEDC_BA98_7654_3210, 8'd3));     // abandon open frame
    send_item(data_item(8'h01));
    send_item(data_item(8'h7E));
    send_item(data_item(8'hFE));
    send_item(start_item(64'h8000_0000_0000_0001, 8'd2));
    send_item(data_item(8'h55));
    send_item(data_item(8'hAA));
    send_item(start_item(64'h7FFF_FFFF_FFFF_FFFE, 8'd128));
    send_item(data_item(8'h3C));
    send_item(start_item(rand_addr(), 8'd0));
    settle();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          program_regs(8'hFF, 8'hFF, 8'hFF, 1'b0);
          tx_quiet = 1'b1;
          rx_quiet = 1'b1;
        end
        2: begin
          program_regs(8'h00, 8'h00, 8'h00, 1'b0);
          tx_quiet = 1'b0;
          rx_quiet = 1'b0;
        end
        default: begin
          program_regs(8'($urandom), 8'($urandom), 8'($urandom), phase == 3);
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
      endcase
      // Hold the result side while the input keeps coming
      if (phase == 4) begin
        tx_quiet = 1'b1;
        hold_request = 1'b1;
      end

      budget = PHASE_ITEMS;
      while (budget > 0) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          len = $urandom_range(0, 10);
          send_item(start_item(rand_addr(), 8'(len)));
          n = len;
          if (len > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, len - 1);
          for (int k = 0; k < n; k++) send_item(data_item(8'($urandom)));
          budget -= n + 1;
        end else if (r < 87) begin
          send_item(data_item(8'($urandom)));
        end else begin
          // long frame, left open for the next start to abandon
          len = $urandom_range(11, 255);
          send_item(start_item(rand_addr(), 8'(len)));
          n = $urandom_range(0, 5);
          for (int k = 0; k < n; k++) send_item(data_item(8'($urandom)));
          budget -= n + 1;
        end
      end
      settle();
    end

    $display("covered %0d frame starts, %0d payload items and %0d dropped items",
             sb.starts, sb.payload_items, sb.ignored_items);
    $display("checked %0d bytes in %0d closed frames over %0d register settings, %0d long stalls",
             sb.checked, sb.frames_closed, settings_done, holds_done);
    if (sb.pending_bytes.size() != 0)
      $display("%0d expected bytes never arrived", sb.pending_bytes.size());
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/atrf_pkg.sv
rtl/atrf_front.sv
rtl/atrf_cmd_queue.sv
rtl/atrf_back.sv
rtl/api_tx_request_framer.sv
tb/tb_api_tx_request_framer.sv
